// ===== hw/rtl/ccp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccp_pkg
// Types, constants and per-byte update functions for the control command
// parser: token matching, decimal accumulation and result classification.
// ----------------------------------------------------------------------------
package ccp_pkg;

   // message length bound and the width of the saturating byte counter
   localparam int MAX_MESSAGE_BYTES = 256;
   localparam int MSG_CNT_W         = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam logic [MSG_CNT_W-1:0] MSG_LIMIT = MSG_CNT_W'(MAX_MESSAGE_BYTES);

   // field widths
   localparam int KIND_W = 3;
   localparam int MCC_W  = 10;
   localparam int MNC_W  = 10;
   localparam int TAC_W  = 24;
   localparam int CELL_W = 36;
   localparam int IMSI_W = 50;
   localparam int ACC_W  = IMSI_W;
   localparam int MUL_W  = ACC_W + 4;

   // token length counter saturates just past the longest keyword
   localparam int CHR_W = 4;
   localparam logic [CHR_W-1:0] CHR_SAT = CHR_W'(9);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_CELL_ID       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_IMSI          = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_CID       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_IMSI      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_IDENT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NO_IDENT      = 3'd5;
   localparam logic [KIND_W-1:0] KIND_UNKNOWN_CMD   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_OVERFLOW      = 3'd7;

   // characters
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // numeric field limits
   localparam logic [ACC_W-1:0] MAX_3DIGIT = ACC_W'(999);
   localparam logic [ACC_W-1:0] MAX_TAC    = ACC_W'(64'd16777215);
   localparam logic [ACC_W-1:0] MAX_CELL   = ACC_W'(64'd68719476735);
   localparam logic [ACC_W-1:0] MAX_IMSI   = ACC_W'(64'd999999999999999);

   // token indexes
   localparam logic [2:0] TOK_CMD   = 3'd0;
   localparam logic [2:0] TOK_SUB   = 3'd1;
   localparam logic [2:0] TOK_F0    = 3'd2;
   localparam logic [2:0] TOK_F2    = 3'd4;
   localparam logic [2:0] TOK_F3    = 3'd5;
   localparam logic [2:0] TOK_SAT   = 3'd7;

   // parser state
   typedef struct packed {
      logic                 in_msg;
      logic                 pending_cr;
      logic [2:0]           tok;
      logic [CHR_W-1:0]     chr;
      logic [MSG_CNT_W-1:0] bytes;
      logic                 m_cid;
      logic                 m_ident;
      logic                 m_imsi;
      logic                 m_n;
      logic                 nums_ok;
      logic                 digits_done;
      logic [ACC_W-1:0]     acc;
      logic                 acc_big;
      logic                 num_ok;
      logic [IMSI_W-1:0]    held0;
      logic [MNC_W-1:0]     held1;
      logic [TAC_W-1:0]     held2;
      logic [CELL_W-1:0]    held3;
   } parse_state_type;

   // one result item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              is_nr;
      logic [MCC_W-1:0]  country_code;
      logic [MNC_W-1:0]  network_code;
      logic [TAC_W-1:0]  area_code;
      logic [CELL_W-1:0] cell_number;
      logic [IMSI_W-1:0] subscriber_id;
   } result_type;

   localparam parse_state_type PARSE_RESET = '{
      in_msg: 1'b0, pending_cr: 1'b0, tok: '0, chr: '0, bytes: '0,
      m_cid: 1'b0, m_ident: 1'b0, m_imsi: 1'b0, m_n: 1'b0,
      nums_ok: 1'b0, digits_done: 1'b0, acc: '0, acc_big: 1'b0,
      num_ok: 1'b1, held0: '0, held1: '0, held2: '0, held3: '0};

   // keyword letters
   function automatic logic [7:0] cid_char(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h43; // C
         2'd1:    r = 8'h49; // I
         2'd2:    r = 8'h44; // D
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] ident_char(input logic [2:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0:    r = 8'h49; // I
         3'd1:    r = 8'h44; // D
         3'd2:    r = 8'h45; // E
         3'd3:    r = 8'h4E; // N
         3'd4:    r = 8'h54; // T
         3'd5:    r = 8'h49; // I
         3'd6:    r = 8'h54; // T
         3'd7:    r = 8'h59; // Y
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] imsi_char(input logic [1:0] idx);
      logic [7:0] r;
      case (idx)
         2'd0:    r = 8'h49; // I
         2'd1:    r = 8'h4D; // M
         2'd2:    r = 8'h53; // S
         2'd3:    r = 8'h49; // I
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // clear per-token state
   function automatic parse_state_type start_token(input parse_state_type s);
      parse_state_type r;
      r             = s;
      r.chr         = '0;
      r.acc         = '0;
      r.acc_big     = 1'b0;
      r.num_ok      = 1'b1;
      r.digits_done = 1'b0;
      return r;
   endfunction

   // a slash opens a fresh message
   function automatic parse_state_type start_message(input parse_state_type s);
      parse_state_type r;
      r            = s;
      r.in_msg     = 1'b1;
      r.pending_cr = 1'b0;
      r.tok        = '0;
      r.bytes      = '0;
      r.m_cid      = 1'b1;
      r.m_ident    = 1'b1;
      r.m_imsi     = 1'b1;
      r.m_n        = 1'b1;
      r.nums_ok    = 1'b1;
      r.held0      = '0;
      r.held1      = '0;
      r.held2      = '0;
      r.held3      = '0;
      return start_token(r);
   endfunction

   // length checks of a finished token, store numeric fields
   function automatic parse_state_type end_token(input parse_state_type s);
      parse_state_type  r;
      logic [ACC_W-1:0] limit;
      logic             ok;
      r = s;
      if (s.m_cid) begin
         if (s.tok == TOK_F2)      limit = MAX_TAC;
         else if (s.tok == TOK_F3) limit = MAX_CELL;
         else                      limit = MAX_3DIGIT;
      end else begin
         limit = MAX_IMSI;
      end
      ok = s.num_ok && (s.chr != '0) && !s.acc_big && (s.acc <= limit);
      if (s.tok == TOK_CMD) begin
         if (s.chr != CHR_W'(3)) r.m_cid   = 1'b0;
         if (s.chr != CHR_W'(8)) r.m_ident = 1'b0;
      end else if (s.tok == TOK_SUB) begin
         if (s.chr != CHR_W'(4)) r.m_imsi = 1'b0;
         if (s.chr != CHR_W'(1)) r.m_n    = 1'b0;
      end else if (s.tok inside {[TOK_F0:TOK_F3]}) begin
         if (!ok) begin
            r.nums_ok = 1'b0;
         end else begin
            case (s.tok - TOK_F0)
               3'd0:    r.held0 = s.acc;
               3'd1:    r.held1 = s.acc[MNC_W-1:0];
               3'd2:    r.held2 = s.acc[TAC_W-1:0];
               default: r.held3 = s.acc[CELL_W-1:0];
            endcase
         end
      end
      return r;
   endfunction

   // one byte of message content
   function automatic parse_state_type content_byte(input parse_state_type s,
                                                    input logic [7:0] c);
      parse_state_type  r;
      logic [MUL_W-1:0] prod;
      r    = s;
      prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1)
           + MUL_W'(c - CH_ZERO);
      if (s.bytes <= MSG_LIMIT) r.bytes = s.bytes + 1'b1;
      if (r.bytes <= MSG_LIMIT) begin
         if (c == CH_COMMA) begin
            r = end_token(r);
            if (r.tok != TOK_SAT) r.tok = r.tok + 1'b1;
            r = start_token(r);
         end else begin
            if (s.tok == TOK_CMD) begin
               if (s.chr >= CHR_W'(3) || c != cid_char(s.chr[1:0]))
                  r.m_cid = 1'b0;
               if (s.chr >= CHR_W'(8) || c != ident_char(s.chr[2:0]))
                  r.m_ident = 1'b0;
            end else if (s.tok == TOK_SUB) begin
               if (s.chr >= CHR_W'(4) || c != imsi_char(s.chr[1:0]))
                  r.m_imsi = 1'b0;
               if (s.chr != '0 || c != CH_N) r.m_n = 1'b0;
            end else if (s.tok <= TOK_F3) begin
               if (!s.digits_done && s.num_ok) begin
                  if (c >= CH_ZERO && c <= CH_NINE) begin
                     // anything beyond the largest limit stays out of range
                     if (!s.acc_big) begin
                        if (prod > {4'b0, MAX_IMSI}) r.acc_big = 1'b1;
                        else                         r.acc     = prod[ACC_W-1:0];
                     end
                  end else if (s.chr == '0) begin
                     r.num_ok = 1'b0;
                  end else begin
                     r.digits_done = 1'b1;
                  end
               end
            end
            if (s.chr != CHR_SAT) r.chr = s.chr + 1'b1;
         end
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/control_command_parser.sv =====
// ----------------------------------------------------------------------------
// control_command_parser
// Byte-serial parser for slash-framed control messages ending in CR LF.
// Recognizes cell identity and IMSI messages and reports one result each.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake               payload
//   req_      in          req_valid / req_stall   req_rx_byte
//   rsp_      out         rsp_valid / rsp_stall   rsp_kind, rsp_is_nr, codes, ids
//
// One byte is taken every cycle while req_stall is low; all parsing for a byte is done in one pass
// between the parser state registers and the result register.
// A result appears on rsp_ in the cycle after the LF that closes its message is taken.
// req_stall is high only while a result is held and rsp_stall is high.
// Synchronous active-high reset puts the parser in slash hunting and clears
// the valid flag of the result register.
//
module control_command_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ccp_pkg::KIND_W-1:0]    rsp_kind,
   output logic                          rsp_is_nr,
   output logic [ccp_pkg::MCC_W-1:0]     rsp_country_code,
   output logic [ccp_pkg::MNC_W-1:0]     rsp_network_code,
   output logic [ccp_pkg::TAC_W-1:0]     rsp_area_code,
   output logic [ccp_pkg::CELL_W-1:0]    rsp_cell_number,
   output logic [ccp_pkg::IMSI_W-1:0]    rsp_subscriber_id
);
   import ccp_pkg::*;

   parse_state_type st_ff, st_in;
   result_type      res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            res_hit;
   logic            accept;
   logic            load_rsp;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign load_rsp  = !rsp_valid_ff || !rsp_stall;

   // per-byte parse step
   always_comb begin
      parse_state_type s;
      logic            fin;
      logic [3:0]      cnt;
      s       = st_ff;
      fin     = 1'b0;
      cnt     = '0;
      res_hit = 1'b0;
      res_in  = '0;
      if (!st_ff.in_msg) begin
         if (req_rx_byte == CH_SLASH) s = start_message(st_ff);
      end else begin
         // a held CR counts as content unless LF follows
         if (s.pending_cr) begin
            if (req_rx_byte == CH_LF) begin
               fin = 1'b1;
            end else begin
               s.pending_cr = 1'b0;
               s = content_byte(s, CH_CR);
            end
         end
         if (fin) begin
            s.in_msg     = 1'b0;
            s.pending_cr = 1'b0;
            if (s.bytes > MSG_LIMIT) begin
               res_hit     = 1'b1;
               res_in.kind = KIND_OVERFLOW;
            end else begin
               cnt = {1'b0, s.tok};
               if (s.chr != '0) begin
                  s   = end_token(s);
                  cnt = cnt + 1'b1;
               end
               if (cnt != '0) begin
                  res_hit = 1'b1;
                  if (s.m_cid) begin
                     if (cnt == 4'd6 && s.nums_ok) begin
                        res_in.kind         = KIND_CELL_ID;
                        res_in.is_nr        = s.m_n;
                        res_in.country_code = s.held0[MCC_W-1:0];
                        res_in.network_code = s.held1;
                        res_in.area_code    = s.held2;
                        res_in.cell_number  = s.held3;
                     end else begin
                        res_in.kind = KIND_BAD_CID;
                     end
                  end else if (s.m_ident) begin
                     if (cnt <= 4'd1) begin
                        res_in.kind = KIND_NO_IDENT;
                     end else if (!s.m_imsi) begin
                        res_in.kind = KIND_UNKNOWN_IDENT;
                     end else if (cnt != 4'd3 || !s.nums_ok) begin
                        res_in.kind = KIND_BAD_IMSI;
                     end else begin
                        res_in.kind          = KIND_IMSI;
                        res_in.subscriber_id = s.held0;
                     end
                  end else begin
                     res_in.kind = KIND_UNKNOWN_CMD;
                  end
               end
            end
         end else if (req_rx_byte == CH_CR) begin
            s.pending_cr = 1'b1;
         end else begin
            s = content_byte(s, req_rx_byte);
         end
      end
      st_in = s;
   end

   assign rsp_valid_in = accept && res_hit;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= PARSE_RESET;
      end else if (accept) begin
         st_ff <= st_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp && rsp_valid_in) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = res_ff.kind;
   assign rsp_is_nr         = res_ff.is_nr;
   assign rsp_country_code  = res_ff.country_code;
   assign rsp_network_code  = res_ff.network_code;
   assign rsp_area_code     = res_ff.area_code;
   assign rsp_cell_number   = res_ff.cell_number;
   assign rsp_subscriber_id = res_ff.subscriber_id;

endmodule

// ===== tb/sv/tb_control_command_parser.sv =====
// ----------------------------------------------------------------------------
// tb_control_command_parser
// Self-checking bench for the control command parser. Byte streams of framed
// cell id, identity and malformed messages are pushed through the request
// channel with random gaps and back-pressure. A bit-accurate parser model
// predicts every report, and each report taken from the block is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_control_command_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import ccp_pkg::*;

   localparam int              ITEMS       = 1500;
   localparam int              HOLD_CYCLES = 200;
   localparam int unsigned     MSG_BOUND   = MAX_MESSAGE_BYTES;
   localparam longint unsigned ACC_CAP     = 64'd100000000000000000;
   localparam longint unsigned TOP_3DIGIT  = 64'd999;
   localparam longint unsigned TOP_TAC     = 64'd16777215;
   localparam longint unsigned TOP_CELL    = 64'd68719476735;
   localparam longint unsigned TOP_IMSI    = 64'd999999999999999;

   // parser model and queue of reports still owed by the block
   class message_scoreboard;
      bit              in_msg, cr_held;
      bit              is_cid, is_ident, is_imsi, is_n, nums_good;
      bit              digits_end, num_good;
      int unsigned     tok_idx, tok_len, msg_len;
      longint unsigned acc;
      longint unsigned held[4];
      result_type      reports[$];
      int unsigned     failures, bytes_parsed, reports_checked;
      string           cid_word   = "CID";
      string           ident_word = "IDENTITY";
      string           imsi_word  = "IMSI";

      function new();
         num_good = 1'b1;
      endfunction

      function void restart_token();
         tok_len    = 0;
         acc        = 0;
         num_good   = 1'b1;
         digits_end = 1'b0;
      endfunction

      // keyword length checks and numeric field capture at a token end
      function void finish_token();
         longint unsigned top;
         if (tok_idx == 0) begin
            if (tok_len != 3) is_cid = 1'b0;
            if (tok_len != 8) is_ident = 1'b0;
         end else if (tok_idx == 1) begin
            if (tok_len != 4) is_imsi = 1'b0;
            if (tok_len != 1) is_n = 1'b0;
         end else if (tok_idx <= 5) begin
            if (!is_cid)           top = TOP_IMSI;
            else if (tok_idx == 4) top = TOP_TAC;
            else if (tok_idx == 5) top = TOP_CELL;
            else                   top = TOP_3DIGIT;
            if (num_good && tok_len > 0 && acc <= top) held[tok_idx-2] = acc;
            else nums_good = 1'b0;
         end
      endfunction

      // one byte of message content
      function void add_content(logic [7:0] c);
         if (msg_len <= MSG_BOUND) msg_len++;
         if (msg_len > MSG_BOUND) return;
         if (c == CH_COMMA) begin
            finish_token();
            if (tok_idx < 7) tok_idx++;
            restart_token();
            return;
         end
         if (tok_idx == 0) begin
            if (tok_len >= 3 || c != cid_word[tok_len]) is_cid = 1'b0;
            if (tok_len >= 8 || c != ident_word[tok_len]) is_ident = 1'b0;
         end else if (tok_idx == 1) begin
            if (tok_len >= 4 || c != imsi_word[tok_len]) is_imsi = 1'b0;
            if (tok_len != 0 || c != CH_N) is_n = 1'b0;
         end else if (tok_idx <= 5) begin
            if (!digits_end && num_good) begin
               if (c >= CH_ZERO && c <= CH_NINE) begin
                  if (acc >= ACC_CAP) begin
                     acc = ACC_CAP;
                  end else begin
                     acc = acc * 10 + (c - CH_ZERO);
                     if (acc > ACC_CAP) acc = ACC_CAP;
                  end
               end else if (tok_len == 0) begin
                  num_good = 1'b0;
               end else begin
                  digits_end = 1'b1;
               end
            end
         end
         if (tok_len < 255) tok_len++;
      endfunction

      // note an accepted request byte, queue the report it closes if any
      function void note_byte(logic [7:0] b);
         result_type  r;
         int unsigned count;
         if (!in_msg) begin
            if (b != CH_SLASH) return;
            bytes_parsed++;
            in_msg    = 1'b1;
            cr_held   = 1'b0;
            tok_idx   = 0;
            msg_len   = 0;
            is_cid    = 1'b1;
            is_ident  = 1'b1;
            is_imsi   = 1'b1;
            is_n      = 1'b1;
            nums_good = 1'b1;
            held      = '{default: 0};
            restart_token();
            return;
         end
         bytes_parsed++;
         if (cr_held) begin
            if (b == CH_LF) begin
               in_msg  = 1'b0;
               cr_held = 1'b0;
               r       = '0;
               if (msg_len > MSG_BOUND) begin
                  r.kind = KIND_OVERFLOW;
                  reports.insert(reports.size(), r);
                  return;
               end
               count = tok_idx;
               if (tok_len > 0) begin
                  finish_token();
                  count++;
               end
               if (count == 0) return;
               if (is_cid) begin
                  if (count == 6 && nums_good) begin
                     r.kind         = KIND_CELL_ID;
                     r.is_nr        = is_n;
                     r.country_code = held[0][MCC_W-1:0];
                     r.network_code = held[1][MNC_W-1:0];
                     r.area_code    = held[2][TAC_W-1:0];
                     r.cell_number  = held[3][CELL_W-1:0];
                  end else begin
                     r.kind = KIND_BAD_CID;
                  end
               end else if (is_ident) begin
                  if (count <= 1)                     r.kind = KIND_NO_IDENT;
                  else if (!is_imsi)                  r.kind = KIND_UNKNOWN_IDENT;
                  else if (count != 3 || !nums_good)  r.kind = KIND_BAD_IMSI;
                  else begin
                     r.kind          = KIND_IMSI;
                     r.subscriber_id = held[0][IMSI_W-1:0];
                  end
               end else begin
                  r.kind = KIND_UNKNOWN_CMD;
               end
               reports.insert(reports.size(), r);
               return;
            end
            // lone carriage return is plain content
            cr_held = 1'b0;
            add_content(CH_CR);
         end
         if (b == CH_CR) begin
            cr_held = 1'b1;
            return;
         end
         add_content(b);
      endfunction

      // compare one report from the block against the oldest prediction
      function void check_report(result_type got);
         result_type      want;
         longint unsigned w[7], g[7];
         string           label[7];
         label = '{"kind", "is_nr", "country_code", "network_code", "area_code",
                   "cell_number", "subscriber_id"};
         reports_checked++;
         if (reports.size() == 0) begin
            failures++;
            $display("%0t: unexpected report, expected none, actual kind %0d",
                     $time, got.kind);
            return;
         end
         want = reports.pop_front();
         w = '{want.kind, want.is_nr, want.country_code, want.network_code,
               want.area_code, want.cell_number, want.subscriber_id};
         g = '{got.kind, got.is_nr, got.country_code, got.network_code,
               got.area_code, got.cell_number, got.subscriber_id};
         for (int i = 0; i < 7; i++) begin
            if (w[i] != g[i]) begin
               failures++;
               $display("%0t: %s mismatch, expected %0d, actual %0d",
                        $time, label[i], w[i], g[i]);
            end
         end
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [7:0]          req_rx_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [KIND_W-1:0]   rsp_kind;
   logic                rsp_is_nr;
   logic [MCC_W-1:0]    rsp_country_code;
   logic [MNC_W-1:0]    rsp_network_code;
   logic [TAC_W-1:0]    rsp_area_code;
   logic [CELL_W-1:0]   rsp_cell_number;
   logic [IMSI_W-1:0]   rsp_subscriber_id;

   bit                  sender_gaps = 1'b1;
   bit                  sink_gaps   = 1'b1;
   int                  holds_asked = 0;
   int                  holds_done  = 0;
   int                  hold_left   = 0;
   int                  burst_left  = 0;
   message_scoreboard   sb          = new();

   control_command_parser u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_is_nr         (rsp_is_nr),
      .rsp_country_code  (rsp_country_code),
      .rsp_network_code  (rsp_network_code),
      .rsp_area_code     (rsp_area_code),
      .rsp_cell_number   (rsp_cell_number),
      .rsp_subscriber_id (rsp_subscriber_id)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response back-pressure: long hold on request, else short random bursts
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left  = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (burst_left != 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if (sink_gaps && $urandom_range(0, 6) == 0) begin
         burst_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // report monitor
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind          = rsp_kind;
         got.is_nr         = rsp_is_nr;
         got.country_code  = rsp_country_code;
         got.network_code  = rsp_network_code;
         got.area_code     = rsp_area_code;
         got.cell_number   = rsp_cell_number;
         got.subscriber_id = rsp_subscriber_id;
         sb.check_report(got);
      end
   end

   // one request, then an optional idle burst
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   // slash, body, then CR LF or a CR that does not close the message
   task automatic send_frame(input string body, input bit broken);
      logic [7:0] tail;
      send_byte(CH_SLASH);
      for (int i = 0; i < body.len(); i++) send_byte(body[i]);
      send_byte(CH_CR);
      tail = 8'($urandom_range(0, 255));
      if (tail == CH_LF) tail = 8'h0B;
      send_byte(broken ? tail : CH_LF);
   endtask

   // sender goes idle until every predicted report has been taken
   task automatic wait_for_reports();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.reports.size() != 0) @(posedge clock);
   endtask

   function automatic string decimal(longint unsigned v);
      return $sformatf("%0d", v);
   endfunction

   // printable token without commas
   function automatic string junk_word(int unsigned maxlen);
      string      s;
      logic [7:0] ch;
      s = "";
      repeat ($urandom_range(0, maxlen)) begin
         ch = 8'($urandom_range(8'h21, 8'h7E));
         if (ch == CH_COMMA) ch = 8'h51;
         s = $sformatf("%s%c", s, ch);
      end
      return s;
   endfunction

   // numeric token, always well formed when clean is set, else possibly malformed
   function automatic string number_token(longint unsigned top, bit clean);
      longint unsigned v;
      string           s;
      v = {$urandom, $urandom};
      v = v % (top + 1);
      if ($urandom_range(0, 3) == 0) v = 64'($urandom_range(0, 20));
      case (clean ? $urandom_range(0, 3) : $urandom_range(0, 9))
         0:       s = decimal(v);
         1:       s = decimal(top);
         2:       s = {"00", decimal(v)};
         3:       s = {decimal(v), "x7"};
         4:       s = "";
         5:       s = {" ", decimal(v)};
         6:       s = $urandom_range(0, 1) ? {"-", decimal(v)} : {"+", decimal(v)};
         7:       s = decimal(top + 1);
         8:       s = "123456789012345678901234";
         default: s = {"a", decimal(v)};
      endcase
      return s;
   endfunction

   // random message body, mostly well formed
   function automatic string message_body();
      string s, radio;
      bit    clean;
      int    p;
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5, 6: begin
            case ($urandom_range(0, 4))
               0, 1:    radio = "N";
               2:       radio = "L";
               3:       radio = "NR";
               default: radio = junk_word(3);
            endcase
            clean = $urandom_range(0, 3) != 0;
            s = {"CID,", radio, ",", number_token(TOP_3DIGIT, clean), ",",
                 number_token(TOP_3DIGIT, clean), ",", number_token(TOP_TAC, clean),
                 ",", number_token(TOP_CELL, clean)};
            case ($urandom_range(0, 9))
               0:       s = {s, ",", junk_word(4)};
               1:       s = {s, ","};
               2:       s = "CID,N,1,2,3";
               3:       s = {"cid", s.substr(3, s.len() - 1)};
               default: ;
            endcase
         end
         7, 8, 9, 10, 11, 12: begin
            case ($urandom_range(0, 9))
               0:       s = "IDENTITY";
               1:       s = {"IDENTITY,", junk_word(6)};
               2:       s = "IDENTITY,IMSI";
               3:       s = {"IDENTITY,IMSI,", number_token(TOP_IMSI, 1'b1), ",",
                             junk_word(3)};
               4:       s = {"IDENTITY,IMS,", number_token(TOP_IMSI, 1'b1)};
               default: s = {"IDENTITY,IMSI,",
                             number_token(TOP_IMSI, $urandom_range(0, 3) != 0)};
            endcase
         end
         13, 14, 15: begin
            case ($urandom_range(0, 5))
               0:       s = "CI";
               1:       s = "IDENTIT,IMSI,5";
               2:       s = "CIDX,N,1,2,3,4";
               3:       s = "IDENTITYX,IMSI";
               default: s = {junk_word(10), ",", junk_word(5)};
            endcase
         end
         16: begin
            // around and past the message length bound
            s = $urandom_range(0, 1) ? "CID," : "";
            p = $urandom_range(0, 2) ? $urandom_range(255, 258) : $urandom_range(259, 320);
            while (s.len() < p) s = $sformatf("%s%c", s, 8'($urandom_range(32, 126)));
         end
         default: s = "";
      endcase
      // lone carriage return somewhere in the content
      if ($urandom_range(0, 7) == 0) begin
         p = $urandom_range(0, s.len());
         s = {s.substr(0, p - 1), $sformatf("%c", CH_CR), s.substr(p, s.len() - 1)};
      end
      // stray byte of any value
      if ($urandom_range(0, 9) == 0 && s.len() > 0)
         s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
      return s;
   endfunction

   // stimulus
   initial begin
      int unsigned msg_no;
      logic [7:0]  noise;
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: byte extremes while hunting, empty message, slash and lone
      // carriage return as content, a lone comma
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame("", 1'b0);
      send_frame($sformatf("/%c", CH_CR), 1'b0);
      send_frame(",", 1'b0);
      wait_for_reports();

      // random messages with noise between them
      msg_no = 0;
      while (sb.bytes_parsed < ITEMS) begin
         msg_no++;
         if (msg_no == 30) holds_asked++;
         if (msg_no == 20) wait_for_reports();
         if (sb.bytes_parsed > ITEMS - 300) begin
            sender_gaps = 1'b0;
            sink_gaps   = 1'b0;
         end
         repeat ($urandom_range(0, 2)) begin
            noise = 8'($urandom_range(0, 255));
            if (noise == CH_SLASH) noise = 8'h2E;
            send_byte(noise);
         end
         send_frame(message_body(), $urandom_range(0, 19) == 0);
      end
      @(negedge clock) req_valid <= 1'b0;

      wait_for_reports();
      repeat (8) @(posedge clock);
      if (sb.failures == 0)
         $display("[control_command_parser] OK");
      else
         $display("[control_command_parser] ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("[control_command_parser] ERROR");
      $finish;
   end

endmodule
